/* rtl/irt_pkg.sv */
// ----------------------------------------------------------------------------
// irt_pkg
// Types and codes shared by the interval reservation table modules.
// ----------------------------------------------------------------------------
package irt_pkg;

    // Limits of the row and seat numbering; the item fields are 10 bits wide.
    localparam int ROWS  = 1024;
    localparam int SEATS = 1024;

    localparam int SEAT_W  = 10;
    localparam int ROW_W   = 10;
    localparam int OWNER_W = 16;

    localparam logic CMD_RESERVE = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;

    localparam logic [2:0] ST_BOOKED  = 3'd0;
    localparam logic [2:0] ST_OVERLAP = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_OWNED   = 3'd3;
    localparam logic [2:0] ST_FREE    = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    typedef struct packed {
        logic               cmd;
        logic [ROW_W-1:0]   row_index;
        logic [SEAT_W-1:0]  start_seat;
        logic [SEAT_W-1:0]  end_seat;
        logic [OWNER_W-1:0] owner_id;
    } t_irt_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [OWNER_W-1:0] found_owner;
    } t_irt_out;

    // One booking as it sits in the table memory.
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [SEAT_W-1:0]  first;
        logic [SEAT_W-1:0]  last;
        logic [OWNER_W-1:0] owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       issue;
        logic       write;
        logic       emit;
        logic [2:0] code;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;
        logic is_lookup;
        logic more;
        logic pend;
        logic hit;
        logic full;
    } t_dp_stat;

endpackage

/* rtl/interval_reservation_table.sv */
// ----------------------------------------------------------------------------
// interval_reservation_table
// Table of booked seat ranges per row with overlap-checked reservation and
// owner lookup.
// ----------------------------------------------------------------------------
// An item is transferred at a rising edge where start is high and busy is
// low. cmd selects a reserve of start_seat..end_seat in row_index for
// owner_id, or a lookup of the owner of start_seat in row_index.
// Exactly one result per item appears on o_result with o_strobe high for a
// single cycle; the receiver cannot stall, so it must take it then.
// Bookings are stored in order in one memory, and a fill count marks which
// entries hold bookings. Each item with a valid range walks the held
// entries through the memory read port, one entry per cycle into one
// range comparator, and stops at a lookup hit or an overlap, else after
// the last booking. An item with a bad range gets its result straight
// after the range check and does not scan. Busy stays high until the
// result is shown; the next item can be transferred in the strobe cycle.
// Reset empties the table by clearing the fill count; no clearing pass.
// ----------------------------------------------------------------------------
module interval_reservation_table #(
    parameter int ENTRIES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  irt_pkg::t_irt_in  i_item,
    output logic              busy,
    output logic              o_strobe,
    output irt_pkg::t_irt_out o_result
);
    import irt_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    irt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (ctrl_cmd)
    );

    irt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (ctrl_cmd),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* rtl/irt_ram.sv */
// ----------------------------------------------------------------------------
// irt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module irt_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/irt_datapath.sv */
// ----------------------------------------------------------------------------
// irt_datapath
// Item register, scan address counter, fill count, table memory, overlap
// comparator and result register.
// ----------------------------------------------------------------------------
module irt_datapath #(
    parameter int ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  irt_pkg::t_irt_in   i_item,
    input  irt_pkg::t_ctrl_cmd i_cmd,
    output irt_pkg::t_dp_stat  o_stat,
    output logic               o_strobe,
    output irt_pkg::t_irt_out  o_result
);
    import irt_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int AW = $clog2(ENTRIES);

    t_irt_in          r_item;
    logic [CW-1:0]    r_rd_addr;
    logic [CW-1:0]    r_count;
    logic             r_pend;
    logic             r_strobe;
    t_irt_out         r_result;

    t_entry           rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    t_entry           wr_entry;
    logic [SEAT_W-1:0] q_last;
    logic             match;
    logic             invalid;

    // A lookup is the range start..start, so one comparator serves both.
    assign q_last = (r_item.cmd == CMD_LOOKUP) ? r_item.start_seat : r_item.end_seat;

    assign rd_entry = t_entry'(rd_data);
    assign match = (rd_entry.row == r_item.row_index) &&
                   (rd_entry.first <= q_last) &&
                   (r_item.start_seat <= rd_entry.last);

    always_comb begin
        if (r_item.cmd == CMD_LOOKUP) begin
            invalid = (32'(r_item.row_index) >= ROWS) ||
                      (32'(r_item.start_seat) >= SEATS);
        end else begin
            invalid = (r_item.end_seat < r_item.start_seat) ||
                      (32'(r_item.row_index) >= ROWS) ||
                      (32'(r_item.end_seat) >= SEATS);
        end
    end

    assign wr_entry.row   = r_item.row_index;
    assign wr_entry.first = r_item.start_seat;
    assign wr_entry.last  = r_item.end_seat;
    assign wr_entry.owner = r_item.owner_id;

    irt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.load) begin
                r_pend <= 1'b0;
            end else begin
                r_pend <= i_cmd.issue;
            end
            if (i_cmd.write) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item    <= i_item;
            r_rd_addr <= '0;
        end else if (i_cmd.issue) begin
            r_rd_addr <= r_rd_addr + CW'(1);
        end
        if (i_cmd.emit) begin
            r_result.status      <= i_cmd.code;
            r_result.found_owner <= (i_cmd.code == ST_OWNED) ? rd_entry.owner : '0;
        end
    end

    assign o_stat.invalid   = invalid;
    assign o_stat.is_lookup = (r_item.cmd == CMD_LOOKUP);
    assign o_stat.more      = (r_rd_addr < r_count);
    assign o_stat.pend      = r_pend;
    assign o_stat.hit       = r_pend && match;
    assign o_stat.full      = (r_count == CW'(ENTRIES));

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* rtl/irt_ctrl.sv */
// ----------------------------------------------------------------------------
// irt_ctrl
// Controller: takes an item, checks its range, runs the table scan and
// picks the result code.
// ----------------------------------------------------------------------------
module irt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  irt_pkg::t_dp_stat  i_stat,
    output logic               busy,
    output irt_pkg::t_ctrl_cmd o_cmd
);
    import irt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.invalid ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit || (!i_stat.more && !i_stat.pend)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_CHECK: begin
                if (i_stat.invalid) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = i_stat.is_lookup ? ST_FREE : ST_INVALID;
                end
            end
            S_SCAN: begin
                // Reads are issued one per cycle; the comparator sees each
                // entry in the cycle after its address.
                o_cmd.issue = i_stat.more && !i_stat.hit;
                if (i_stat.hit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = i_stat.is_lookup ? ST_OWNED : ST_OVERLAP;
                end else if (!i_stat.more && !i_stat.pend) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.is_lookup) begin
                        o_cmd.code = ST_FREE;
                    end else if (i_stat.full) begin
                        o_cmd.code = ST_FULL;
                    end else begin
                        o_cmd.code  = ST_BOOKED;
                        o_cmd.write = 1'b1;
                    end
                end
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
